### src/lir_pkg.sv
// ---------------------------------------------------------------------------
// lir_pkg
// Shared types and constants of the linear interpolation resampler: frame
// structs, configuration register indexes and reset values.
// ---------------------------------------------------------------------------
package lir_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned STEP_W     = 21;
  localparam int unsigned CHAN_W     = 2;
  localparam int unsigned FRAMES_W   = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 21;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_FRAMES = 2'd2;

  localparam logic [STEP_W-1:0]   STEP_RATIO_RST    = 21'd65536;
  localparam logic [CHAN_W-1:0]   CHANNEL_COUNT_RST = 2'd1;
  localparam logic [FRAMES_W-1:0] OUTPUT_FRAMES_RST = 13'd960;
  localparam logic [CHAN_W-1:0]   CHAN_STEREO       = 2'd2;

  // Most results per phase (interpolation, tail) of one frame
  localparam int unsigned PHASE_CAP = 16;
  localparam int unsigned CAP_W     = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    sample_t sample_ch0;
    sample_t sample_ch1;
    logic    first_frame;
    logic    last_frame;
  } in_frame_t;

  typedef struct packed {
    sample_t out_ch0;
    sample_t out_ch1;
    logic    end_of_run;
  } out_frame_t;

  // Classified frame handed from the front end to the back end
  typedef struct packed {
    sample_t cur0;
    sample_t cur1;
    sample_t prev0;
    sample_t prev1;
    logic    first;
    logic    last;
  } cmd_t;

endpackage

### src/lir_fifo.sv
// ---------------------------------------------------------------------------
// lir_fifo
// Small first-in first-out queue with push/full and pop/empty sides.
// ---------------------------------------------------------------------------
module lir_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### src/lir_front.sv
// ---------------------------------------------------------------------------
// lir_front
// Front end: takes input frames, tracks the previous frame and the frame
// index within the block, and builds one command per frame.
// ---------------------------------------------------------------------------
module lir_front #(
  parameter int unsigned MAX_CHANNELS     = 2,
  parameter int unsigned MAX_BLOCK_FRAMES = 4096,
  localparam int unsigned IDX_W           = $clog2(MAX_BLOCK_FRAMES)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  lir_pkg::in_frame_t  frame_i,
  input  logic                stereo_i,
  output lir_pkg::cmd_t       cmd_o,
  output logic [IDX_W-1:0]    k_o
);

  lir_pkg::sample_t prev_q [MAX_CHANNELS];
  logic [IDX_W-1:0] index_q;
  logic [IDX_W-1:0] k;
  lir_pkg::sample_t cur1;

  // A first frame restarts the block at index zero
  assign k    = frame_i.first_frame ? '0 : index_q;
  assign cur1 = stereo_i ? frame_i.sample_ch1 : '0;
  assign k_o  = k;

  always_comb begin
    cmd_o.cur0  = frame_i.sample_ch0;
    cmd_o.cur1  = cur1;
    cmd_o.prev0 = prev_q[0];
    cmd_o.prev1 = stereo_i ? prev_q[MAX_CHANNELS-1] : '0;
    cmd_o.first = frame_i.first_frame;
    cmd_o.last  = frame_i.last_frame;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MAX_CHANNELS; c++) begin
        prev_q[c] <= '0;
      end
      index_q <= '0;
    end else if (accept_i) begin
      prev_q[0] <= frame_i.sample_ch0;
      if (stereo_i) begin
        prev_q[MAX_CHANNELS-1] <= cur1;
      end
      // saturate at the last index of a block
      index_q <= (k == IDX_W'(MAX_BLOCK_FRAMES - 1)) ? k : k + 1'b1;
    end
  end

endmodule

### src/lir_back.sv
// ---------------------------------------------------------------------------
// lir_back
// Back end: walks the read position for one command, one result per cycle
// while results have room, through interpolation, then a last frame's tail.
// ---------------------------------------------------------------------------
module lir_back #(
  parameter int unsigned FRAC_BITS        = 16,
  parameter int unsigned MAX_BLOCK_FRAMES = 4096,
  localparam int unsigned IDX_W           = $clog2(MAX_BLOCK_FRAMES)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [lir_pkg::STEP_W-1:0]          step_ratio_i,
  input  logic [lir_pkg::FRAMES_W-1:0]        output_frames_i,
  input  logic                                cmd_empty_i,
  input  lir_pkg::cmd_t                       cmd_i,
  input  logic [IDX_W-1:0]                    k_i,
  output logic                                cmd_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output lir_pkg::out_frame_t                 res_o
);

  localparam int unsigned IP_W   = $clog2(MAX_BLOCK_FRAMES + 1);
  localparam int unsigned POS_W  = IP_W + FRAC_BITS;
  localparam int unsigned SUM_W  =
    ((POS_W > lir_pkg::STEP_W) ? POS_W : lir_pkg::STEP_W) + 1;
  localparam int unsigned PROD_W = FRAC_BITS + lir_pkg::SAMPLE_W + 2;
  localparam int unsigned ACC_W  = PROD_W + 1;
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_BLOCK_FRAMES) << FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_LIMIT = SUM_W'(POS_LIMIT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INTERP,
    ST_TAIL,
    ST_FLUSH
  } state_e;

  // s0 + frac*(s1-s0), truncated toward zero
  function automatic lir_pkg::sample_t lerp(lir_pkg::sample_t s0, lir_pkg::sample_t s1,
                                            logic [FRAC_BITS-1:0] fr);
    logic signed [lir_pkg::SAMPLE_W:0] diff;
    logic signed [FRAC_BITS:0]         frs;
    logic signed [PROD_W-1:0]          prod;
    logic signed [ACC_W-1:0]           base;
    logic signed [ACC_W-1:0]           acc;
    logic signed [ACC_W-1:0]           bias;
    diff = {s1[lir_pkg::SAMPLE_W-1], s1} - {s0[lir_pkg::SAMPLE_W-1], s0};
    frs  = {1'b0, fr};
    prod = PROD_W'(frs) * PROD_W'(diff);
    base = ACC_W'(s0);
    base = base <<< FRAC_BITS;
    acc  = base + ACC_W'(prod);
    bias = {{(ACC_W - FRAC_BITS){1'b0}}, {FRAC_BITS{acc[ACC_W-1]}}};
    acc  = acc + bias;
    return acc[FRAC_BITS +: lir_pkg::SAMPLE_W];
  endfunction

  state_e                        state_q;
  logic [POS_W-1:0]              pos_q;
  logic [lir_pkg::FRAMES_W-1:0]  count_q;
  logic [lir_pkg::CAP_W-1:0]     phase_cnt_q;
  lir_pkg::cmd_t                 cmd_q;
  logic [IDX_W-1:0]              k_q;
  logic                          held_v_q;
  lir_pkg::sample_t              held0_q, held1_q;

  logic [IP_W-1:0]      ip, k_ext;
  logic                 sat, cap_hit, count_done;
  logic                 stop_interp, stop_tail;
  logic [FRAC_BITS-1:0] frac;
  lir_pkg::sample_t     lerp0, lerp1, new0, new1;
  logic [SUM_W-1:0]     pos_sum;
  logic [POS_W-1:0]     pos_next;
  logic                 slot_ok, emit, flush_push;

  assign ip          = pos_q[POS_W-1:FRAC_BITS];
  assign k_ext       = IP_W'(k_q);
  assign sat         = (pos_q >= POS_LIMIT);
  assign cap_hit     = (phase_cnt_q == lir_pkg::CAP_W'(lir_pkg::PHASE_CAP));
  assign count_done  = (count_q >= output_frames_i);
  assign stop_interp = sat || (ip >= k_ext) || count_done || cap_hit;
  assign stop_tail   = sat || (ip > k_ext) || count_done || cap_hit;

  // positions left behind in an earlier interval take fraction zero
  assign frac  = ((ip + 1'b1) == k_ext) ? pos_q[FRAC_BITS-1:0] : '0;
  assign lerp0 = lerp(cmd_q.prev0, cmd_q.cur0, frac);
  assign lerp1 = lerp(cmd_q.prev1, cmd_q.cur1, frac);
  assign new0  = (state_q == ST_TAIL) ? cmd_q.cur0 : lerp0;
  assign new1  = (state_q == ST_TAIL) ? cmd_q.cur1 : lerp1;

  assign pos_sum  = SUM_W'(pos_q) + SUM_W'(step_ratio_i);
  assign pos_next = (pos_sum > SUM_LIMIT) ? POS_LIMIT : pos_sum[POS_W-1:0];

  // The held result goes out once the next one exists or the run closes
  assign slot_ok    = !held_v_q || !res_full_i;
  assign emit       = slot_ok && (((state_q == ST_INTERP) && !stop_interp) ||
                                  ((state_q == ST_TAIL) && !stop_tail));
  assign flush_push = (state_q == ST_FLUSH) && held_v_q && !res_full_i;
  assign res_push_o = (emit && held_v_q) || flush_push;
  assign cmd_pop_o  = (state_q == ST_IDLE) && !cmd_empty_i;

  always_comb begin
    res_o.out_ch0    = held0_q;
    res_o.out_ch1    = held1_q;
    res_o.end_of_run = (state_q == ST_FLUSH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      count_q     <= '0;
      phase_cnt_q <= '0;
      cmd_q       <= '0;
      k_q         <= '0;
      held_v_q    <= 1'b0;
      held0_q     <= '0;
      held1_q     <= '0;
    end else begin
      if (emit) begin
        held0_q     <= new0;
        held1_q     <= new1;
        held_v_q    <= 1'b1;
        pos_q       <= pos_next;
        count_q     <= count_q + 1'b1;
        phase_cnt_q <= phase_cnt_q + 1'b1;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!cmd_empty_i) begin
            cmd_q       <= cmd_i;
            k_q         <= k_i;
            phase_cnt_q <= '0;
            if (cmd_i.first) begin
              pos_q   <= '0;
              count_q <= '0;
            end
            state_q <= ST_INTERP;
          end
        end
        ST_INTERP: begin
          if (stop_interp) begin
            phase_cnt_q <= '0;
            state_q     <= cmd_q.last ? ST_TAIL : ST_FLUSH;
          end
        end
        ST_TAIL: begin
          if (stop_tail) begin
            state_q <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (!held_v_q) begin
            state_q <= ST_IDLE;
          end else if (!res_full_i) begin
            held_v_q <= 1'b0;
            state_q  <= ST_IDLE;
          end
        end
      endcase
    end
  end

endmodule

### src/linear_interp_resampler.sv
// ---------------------------------------------------------------------------
// linear_interp_resampler
// Linear interpolation sample rate converter for one or two 16-bit channels.
//
//   channel   direction  handshake            payload
//   input     in         push / full          in_frame_i  (lir_pkg::in_frame_t)
//   result    out        pop / empty          out_frame_o (lir_pkg::out_frame_t)
//   config    in         cfg_we_i             cfg_idx_i, cfg_data_i
//
// For each frame the back-end sequencer picks up its command, makes results in
// its interpolation phase and, for a last frame, its tail phase, then closes
// the run. It makes one result per cycle while the result queue has room; the
// two-entry command queue lets the front end take frames while it works.
// Results wait in a four-entry queue.
// Reset clears all state but the queue storage at once; no clearing pass.
// ---------------------------------------------------------------------------
module linear_interp_resampler #(
  parameter int unsigned MAX_CHANNELS     = 2,
  parameter int unsigned FRAC_BITS        = 16,
  parameter int unsigned MAX_BLOCK_FRAMES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  lir_pkg::in_frame_t                 in_frame_i,
  output logic                               empty,
  input  logic                               pop,
  output lir_pkg::out_frame_t                out_frame_o,
  input  logic                               cfg_we_i,
  input  logic [lir_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lir_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W   = $clog2(MAX_BLOCK_FRAMES);
  localparam int unsigned CMD_W   = $bits(lir_pkg::cmd_t) + IDX_W;
  localparam int unsigned RES_W   = $bits(lir_pkg::out_frame_t);
  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 4;

  logic [lir_pkg::STEP_W-1:0]   step_ratio_q;
  logic [lir_pkg::CHAN_W-1:0]   channel_count_q;
  logic [lir_pkg::FRAMES_W-1:0] output_frames_q;
  logic                         stereo;
  logic                         accept;

  lir_pkg::cmd_t       front_cmd, back_cmd;
  logic [IDX_W-1:0]    front_k, back_k;
  logic [CMD_W-1:0]    cmd_wdata, cmd_rdata;
  logic                cmd_empty, cmd_pop;
  lir_pkg::out_frame_t res;
  logic [RES_W-1:0]    res_rdata;
  logic                res_push, res_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ratio_q    <= lir_pkg::STEP_RATIO_RST;
      channel_count_q <= lir_pkg::CHANNEL_COUNT_RST;
      output_frames_q <= lir_pkg::OUTPUT_FRAMES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lir_pkg::CFG_STEP_RATIO: begin
          step_ratio_q <= cfg_data_i[lir_pkg::STEP_W-1:0];
        end
        lir_pkg::CFG_CHANNEL_COUNT: begin
          channel_count_q <= cfg_data_i[lir_pkg::CHAN_W-1:0];
        end
        lir_pkg::CFG_OUTPUT_FRAMES: begin
          output_frames_q <= cfg_data_i[lir_pkg::FRAMES_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign stereo = (channel_count_q >= lir_pkg::CHAN_STEREO) && (MAX_CHANNELS >= 2);
  assign accept = push && !full;

  lir_front #(
    .MAX_CHANNELS     (MAX_CHANNELS),
    .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .frame_i  (in_frame_i),
    .stereo_i (stereo),
    .cmd_o    (front_cmd),
    .k_o      (front_k)
  );

  assign cmd_wdata = {front_k, front_cmd};
  assign {back_k, back_cmd} = cmd_rdata;

  lir_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (cmd_wdata),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_rdata),
    .empty_o (cmd_empty)
  );

  lir_back #(
    .FRAC_BITS        (FRAC_BITS),
    .MAX_BLOCK_FRAMES (MAX_BLOCK_FRAMES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_ratio_i    (step_ratio_q),
    .output_frames_i (output_frames_q),
    .cmd_empty_i     (cmd_empty),
    .cmd_i           (back_cmd),
    .k_i             (back_k),
    .cmd_pop_o       (cmd_pop),
    .res_full_i      (res_full),
    .res_push_o      (res_push),
    .res_o           (res)
  );

  lir_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_rdata),
    .empty_o (empty)
  );

  assign out_frame_o = lir_pkg::out_frame_t'(res_rdata);

endmodule

### src/lir_checker.sv
// ---------------------------------------------------------------------------
// lir_checker
// Port-level checks of the resampler, attached to the top level by bind.
// ---------------------------------------------------------------------------
module lir_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               push,
  input logic                               full,
  input logic                               empty,
  input logic                               pop,
  input lir_pkg::out_frame_t                out_frame_o,
  input logic                               cfg_we_i,
  input logic [lir_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input logic [lir_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  logic seen_q;
  logic stereo_q;
  logic in_reset_q;

  // Track whether any frame went in, and the channel mode last written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      stereo_q <= 1'b0;
    end else begin
      if (push && !full) begin
        seen_q <= 1'b1;
      end
      if (cfg_we_i && (cfg_idx_i == lir_pkg::CFG_CHANNEL_COUNT)) begin
        stereo_q <= (cfg_data_i[lir_pkg::CHAN_W-1:0] >= lir_pkg::CHAN_STEREO);
      end
    end
  end

  // Mark edges that follow an edge already seen inside reset
  always_ff @(posedge clk_i) begin
    in_reset_q <= !rst_ni;
  end

  a_reset_queues: assert property (@(posedge clk_i)
    !rst_ni && in_reset_q |-> empty && !full)
    else $error("queues not cleared in reset");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_frame_o))
    else $error("waiting result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !seen_q |-> empty)
    else $error("result appeared before any frame was taken");

  a_mono_ch1_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !stereo_q |-> out_frame_o.out_ch1 == '0)
    else $error("channel 1 result not zero in mono mode");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (.*);
